// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the round helper functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenOffset  = 56;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic start;
   } cmp_ctrl_type;

   function automatic word_type round_const(input logic [5:0] r);
      word_type k;
      case (r)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type rotr(input word_type v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

// ===== rtl/sha256_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Runs 64 rounds, one per cycle, over one block of sixteen message words,
// then adds the working variables into the chaining value.
// ----------------------------------------------------------------------------
module sha256_round (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256_pkg::cmp_ctrl_type ctrl_in,
   output logic                   done,
   input  logic                   reload,
   input  sha256_pkg::word_type   msg_word [16],
   output sha256_pkg::word_type   chain [8]
);

   sha256_pkg::word_type chain_ff [8];
   sha256_pkg::word_type wv_ff [8];
   sha256_pkg::word_type win_ff [16];
   logic [5:0] round_ff;
   logic       busy_ff;
   logic       done_ff;

   sha256_pkg::word_type w, m2, m15, e, a, t1, t2;

   always_comb begin
      m2  = win_ff[round_ff[3:0] - 4'd2];
      m15 = win_ff[round_ff[3:0] - 4'd15];
      if (round_ff < 6'd16) begin
         w = msg_word[round_ff[3:0]];
      end else begin
         w = (sha256_pkg::rotr(m2, 17) ^ sha256_pkg::rotr(m2, 19) ^ (m2 >> 10))
             + win_ff[round_ff[3:0] - 4'd7]
             + (sha256_pkg::rotr(m15, 7) ^ sha256_pkg::rotr(m15, 18) ^ (m15 >> 3))
             + win_ff[round_ff[3:0]];
      end
      a = wv_ff[0];
      e = wv_ff[4];
      t1 = wv_ff[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
           ^ sha256_pkg::rotr(e, 25)) + ((e & wv_ff[5]) ^ (~e & wv_ff[6]))
           + sha256_pkg::round_const(round_ff) + w;
      t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
           + ((a & wv_ff[1]) ^ (a & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha256_pkg::init_hash(3'(i));
      end else begin
         done_ff <= 1'b0;
         if (reload) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= sha256_pkg::init_hash(3'(i));
         end
         if (ctrl_in.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
            for (int i = 0; i < 8; i++) wv_ff[i] <= chain_ff[i];
         end else if (busy_ff) begin
            win_ff[round_ff[3:0]] <= w;
            wv_ff[7] <= wv_ff[6];
            wv_ff[6] <= wv_ff[5];
            wv_ff[5] <= wv_ff[4];
            wv_ff[4] <= wv_ff[3] + t1;
            wv_ff[3] <= wv_ff[2];
            wv_ff[2] <= wv_ff[1];
            wv_ff[1] <= wv_ff[0];
            wv_ff[0] <= t1 + t2;
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               // Feed-forward uses the final round's values directly.
               chain_ff[0] <= chain_ff[0] + t1 + t2;
               chain_ff[1] <= chain_ff[1] + wv_ff[0];
               chain_ff[2] <= chain_ff[2] + wv_ff[1];
               chain_ff[3] <= chain_ff[3] + wv_ff[2];
               chain_ff[4] <= chain_ff[4] + wv_ff[3] + t1;
               chain_ff[5] <= chain_ff[5] + wv_ff[4];
               chain_ff[6] <= chain_ff[6] + wv_ff[5];
               chain_ff[7] <= chain_ff[7] + wv_ff[6];
            end
         end
      end
   end

   assign done  = done_ff;
   assign chain = chain_ff;

endmodule

// ===== rtl/sha256_byte_stream_hasher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Byte-wide SHA-256 with message padding and a word-serial digest.
// ----------------------------------------------------------------------------
// Usage: each req_ beat carries at most one message byte (req_has_byte) and
// may close the message (req_end_of_message). A beat that fills the 64-byte
// block starts a compression in the round engine, one round per cycle, and
// req_stall stays high until that compression is done. Other bytes are taken
// back to back. An end beat pads the block, compresses it, and compresses a
// second block when 8 bytes or fewer were left for the pad byte and length,
// then presents eight rsp_ beats, word 0 first, rsp_last_word on the eighth.
// While rsp_stall is high the current word holds and no new request is
// taken. After the digest the chaining value returns to the initial hash
// for the next message. Reset clears the byte and bit counts and sets the
// chaining value to the initial hash; the block buffer needs no clearing
// since every byte is written before the round engine reads it.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_has_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   localparam int unsigned LenWord = sha256_pkg::LenOffset / 4;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FULL  = 7'b0000010,
      ST_PAD   = 7'b0000100,
      ST_RUN   = 7'b0001000,
      ST_LEN   = 7'b0010000,
      ST_FINAL = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   // Block buffer held as sixteen big-endian words; bytes land in their lane.
   sha256_pkg::word_type buf_ff [16];
   logic [6:0]  fill_ff;
   logic [63:0] bits_ff;
   logic        pend_end_ff;   // end marker follows the current compression
   logic        last_blk_ff;   // current compression is the final one
   logic [2:0]  idx_ff;
   logic        go_ff;
   logic        reload;
   sha256_pkg::cmp_ctrl_type ctrl;
   logic        cmp_done;
   sha256_pkg::word_type chain [8];
   sha256_pkg::word_type pad_keep;
   sha256_pkg::word_type pad_word;
   logic [63:0] total;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign total     = bits_ff + {54'd0, fill_ff[5:0], 3'd0};
   assign ctrl.start = go_ff;

   // Bytes ahead of the pad byte in its word are kept; the rest are cleared.
   assign pad_keep = ~(32'hffff_ffff >> {fill_ff[1:0], 3'b000});
   assign pad_word = {24'd0, sha256_pkg::PadByte} << {~fill_ff[1:0], 3'b000};

   sha256_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (ctrl),
      .done     (cmp_done),
      .reload   (reload),
      .msg_word (buf_ff),
      .chain    (chain)
   );

   assign reload = (state_ff == ST_OUT) && !rsp_stall && (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_has_byte && fill_ff == 7'(sha256_pkg::BlockBytes - 1)) begin
                  state_in = ST_FULL;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_FULL:  state_in = ST_RUN;
         ST_PAD:   state_in = ST_RUN;
         ST_LEN:   state_in = ST_RUN;
         ST_RUN: begin
            if (cmp_done) begin
               if (last_blk_ff) state_in = ST_OUT;
               else if (pend_end_ff) state_in = ST_FINAL;
               // Padded block without room for the length: send a second.
               else if (fill_ff != 7'd0) state_in = ST_LEN;
               else state_in = ST_IDLE;
            end
         end
         // Full block done; now pad the end marker that came with it.
         ST_FINAL: state_in = ST_PAD;
         ST_OUT: begin
            if (!rsp_stall && idx_ff == 3'd7) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         bits_ff     <= '0;
         pend_end_ff <= 1'b0;
         last_blk_ff <= 1'b0;
         idx_ff      <= '0;
         go_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pend_end_ff <= req_end_of_message;
                  if (req_has_byte) begin
                     buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_data_byte;
                     fill_ff <= fill_ff + 7'd1;
                  end
               end
            end
            ST_FULL: begin
               go_ff       <= 1'b1;
               last_blk_ff <= 1'b0;
               bits_ff     <= bits_ff + 64'd512;
               fill_ff     <= '0;
            end
            ST_PAD: begin
               pend_end_ff <= 1'b0;
               for (int j = 0; j < 16; j++) begin
                  if (fill_ff < 7'(sha256_pkg::LenOffset) && j == int'(LenWord)) begin
                     buf_ff[j] <= total[63:32];
                  end else if (fill_ff < 7'(sha256_pkg::LenOffset) && j > int'(LenWord)) begin
                     buf_ff[j] <= total[31:0];
                  end else if (4'(j) == fill_ff[5:2]) begin
                     buf_ff[j] <= (buf_ff[j] & pad_keep) | pad_word;
                  end else if (4'(j) > fill_ff[5:2]) begin
                     buf_ff[j] <= '0;
                  end
               end
               last_blk_ff <= (fill_ff < 7'(sha256_pkg::LenOffset));
               go_ff       <= 1'b1;
            end
            ST_LEN: begin
               for (int j = 0; j < int'(LenWord); j++) buf_ff[j] <= '0;
               buf_ff[4'(LenWord)]     <= total[63:32];
               buf_ff[4'(LenWord + 1)] <= total[31:0];
               last_blk_ff <= 1'b1;
               go_ff       <= 1'b1;
            end
            ST_RUN: begin
               if (cmp_done && last_blk_ff) idx_ff <= '0;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     fill_ff <= '0;
                     bits_ff <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

endmodule
